[sv/assert_macros.svh]
// Assertion macros shared by the green split RTL.
// Needs a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that the antecedent implies the consequent in the same cycle.
`define ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that the antecedent implies the consequent in the following cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/ags_pkg.sv]
// Types and constants for the adaptive green split block.
// No dependencies; imported by the top level.
package ags_pkg;

  // Lane codes, also the green direction encoding
  typedef enum logic [1:0] {
    LANE_N = 2'd0,
    LANE_S = 2'd1,
    LANE_E = 2'd2,
    LANE_W = 2'd3
  } lane_t;

  // Configuration register indexes
  typedef enum logic {
    CFG_CYCLE_SECONDS = 1'b0,
    CFG_SERVICE_RATE  = 1'b1
  } cfg_idx_t;

  // Sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_EVEN,
    S_MUL_GO,
    S_MUL_WAIT,
    S_DIV_GO,
    S_DIV_WAIT,
    S_ADJ,
    S_DIR,
    S_SRV_GO,
    S_SRV_WAIT,
    S_DONE
  } ags_state_t;

  localparam int NUM_LANES   = 4;
  localparam int CYCLE_RESET = 30;

endpackage

[sv/ags_ser_mul.sv]
// Bit-serial shift-add multiplier: one multiplier bit per cycle.
// Standalone; used by the green split top level for q*T and rate*g.
module ags_ser_mul #(
  parameter int A_BITS = 10,
  parameter int B_BITS = 8
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [A_BITS-1:0]        a,
  input  logic [B_BITS-1:0]        b,
  output logic                     done,
  output logic [A_BITS+B_BITS-1:0] prod
);

  localparam int PROD_BITS = A_BITS + B_BITS;
  localparam int CNT_BITS  = $clog2(B_BITS + 1);

  logic [PROD_BITS-1:0] mcand_r;
  logic [PROD_BITS-1:0] acc_r;
  logic [B_BITS-1:0]    mplier_r;
  logic [CNT_BITS-1:0]  cnt_r;
  logic                 busy_r;
  logic                 done_r;

  // Control: count down one step per multiplier bit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_BITS'(B_BITS);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_BITS'(1);
        if (cnt_r == CNT_BITS'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath: add shifted multiplicand when the low multiplier bit is set
  always_ff @(posedge clk) begin
    if (start) begin
      mcand_r  <= PROD_BITS'(a);
      mplier_r <= b;
      acc_r    <= '0;
    end else if (busy_r) begin
      if (mplier_r[0]) begin
        acc_r <= acc_r + mcand_r;
      end
      mcand_r  <= mcand_r << 1;
      mplier_r <= mplier_r >> 1;
    end
  end

  assign done = done_r;
  assign prod = acc_r;

endmodule

[sv/ags_ser_div.sv]
// Restoring divider: one quotient bit per cycle, MSB first.
// Standalone; the caller guarantees the quotient fits in QUO_BITS.
module ags_ser_div #(
  parameter int NUM_BITS = 20,
  parameter int DEN_BITS = 13,
  parameter int QUO_BITS = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [NUM_BITS-1:0] num,
  input  logic [DEN_BITS-1:0] den,
  output logic                done,
  output logic [QUO_BITS-1:0] quot
);

  localparam int CNT_BITS = $clog2(QUO_BITS + 1);

  logic [DEN_BITS-1:0] rem_r;
  logic [DEN_BITS-1:0] den_r;
  logic [QUO_BITS-1:0] low_r;
  logic [QUO_BITS-1:0] quot_r;
  logic [CNT_BITS-1:0] cnt_r;
  logic                busy_r;
  logic                done_r;

  logic [NUM_BITS-1:0] num_hi;
  logic [DEN_BITS:0]   trial;
  logic [DEN_BITS:0]   diff;
  logic                fits;

  // Trial subtract of the divisor from the shifted partial remainder
  always_comb begin
    num_hi = num >> QUO_BITS;
    trial  = {rem_r, low_r[QUO_BITS-1]};
    diff   = trial - {1'b0, den_r};
    fits   = (trial >= {1'b0, den_r});
  end

  // Control: one step per quotient bit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_BITS'(QUO_BITS);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_BITS'(1);
        if (cnt_r == CNT_BITS'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath: shift in numerator bits, keep or restore the remainder
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= num_hi[DEN_BITS-1:0];
      low_r  <= num[QUO_BITS-1:0];
      den_r  <= den;
      quot_r <= '0;
    end else if (busy_r) begin
      rem_r  <= fits ? diff[DEN_BITS-1:0] : trial[DEN_BITS-1:0];
      low_r  <= low_r << 1;
      quot_r <= {quot_r[QUO_BITS-2:0], fits};
    end
  end

  assign done = done_r;
  assign quot = quot_r;

endmodule

[sv/adaptive_signal_green_split_unit.sv]
// One serial multiplier and one serial divider, each CYCLE_BITS steps, are shared over the
// four lanes; all-empty queues skip the multiply-divide split and take an even split.
// One item at a time; the next input beat is taken while a result waits on the output.
// Reset (synchronous, active low) clears control and loads cycle 30 s, service rate 0.5.
`include "assert_macros.svh"

module adaptive_signal_green_split_unit
  import ags_pkg::*;
#(
  parameter int QUEUE_BITS     = 10,
  parameter int CYCLE_BITS     = 8,
  parameter int RATE_FRAC_BITS = 8,
  localparam int RATE_BITS     = RATE_FRAC_BITS + 2,
  localparam int SERVED_BITS   = QUEUE_BITS + 2,
  localparam int CFG_BITS      = (CYCLE_BITS > RATE_BITS) ? CYCLE_BITS : RATE_BITS
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // configuration write port
  input  logic                   cfg_we,
  input  logic                   cfg_index,
  input  logic [CFG_BITS-1:0]    cfg_wdata,
  // input channel
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [QUEUE_BITS-1:0]  in_queue_north,
  input  logic [QUEUE_BITS-1:0]  in_queue_south,
  input  logic [QUEUE_BITS-1:0]  in_queue_east,
  input  logic [QUEUE_BITS-1:0]  in_queue_west,
  input  logic [3:0]             in_override_mask,
  // result channel
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [CYCLE_BITS-1:0]  out_green_north,
  output logic [CYCLE_BITS-1:0]  out_green_south,
  output logic [CYCLE_BITS-1:0]  out_green_east,
  output logic [CYCLE_BITS-1:0]  out_green_west,
  output logic [1:0]             out_green_direction,
  output logic [QUEUE_BITS-1:0]  out_left_north,
  output logic [QUEUE_BITS-1:0]  out_left_south,
  output logic [QUEUE_BITS-1:0]  out_left_east,
  output logic [QUEUE_BITS-1:0]  out_left_west,
  output logic [SERVED_BITS-1:0] out_served_count
);

  localparam int MUL_A_BITS = (QUEUE_BITS > RATE_BITS) ? QUEUE_BITS : RATE_BITS;
  localparam int PROD_BITS  = MUL_A_BITS + CYCLE_BITS;
  localparam int TOTAL_BITS = QUEUE_BITS + 2;
  localparam int NUM_BITS   = PROD_BITS + 2;
  localparam int DEN_BITS   = TOTAL_BITS + 1;
  localparam int SUM_BITS   = CYCLE_BITS + 2;

  // Configuration registers
  logic [CYCLE_BITS-1:0] cycle_r;
  logic [RATE_BITS-1:0]  rate_r;

  // Sequencer and working registers
  ags_state_t            state_r, state_nxt;
  logic [1:0]            idx_r, idx_nxt;
  logic [QUEUE_BITS-1:0] q_r [NUM_LANES];
  logic [3:0]            mask_r;
  logic [TOTAL_BITS-1:0] total_r;
  logic [CYCLE_BITS-1:0] g_r [NUM_LANES];
  logic [CYCLE_BITS-1:0] g_nxt [NUM_LANES];
  logic [QUEUE_BITS-1:0] left_r [NUM_LANES];
  logic [QUEUE_BITS-1:0] left_nxt [NUM_LANES];
  logic [SERVED_BITS-1:0] served_r, served_nxt;
  lane_t                 dir_r, dir_nxt;

  // Output registers
  logic                   out_valid_r, out_valid_nxt;
  logic                   out_load;
  logic [CYCLE_BITS-1:0]  out_g_r [NUM_LANES];
  logic [QUEUE_BITS-1:0]  out_left_r [NUM_LANES];
  logic [1:0]             out_dir_r;
  logic [SERVED_BITS-1:0] out_served_r;

  // Shared arithmetic units
  logic                  mul_start, mul_done;
  logic [MUL_A_BITS-1:0] mul_a;
  logic [CYCLE_BITS-1:0] mul_b;
  logic [PROD_BITS-1:0]  mul_prod;
  logic                  div_start, div_done;
  logic [NUM_BITS-1:0]   div_num;
  logic [DEN_BITS-1:0]   div_den;
  logic [CYCLE_BITS-1:0] div_quot;

  // Combinational helpers
  logic                  in_accept;
  logic [TOTAL_BITS-1:0] in_total;
  logic [SUM_BITS-1:0]   gsum;
  logic [SUM_BITS-1:0]   t_ext;
  logic                  trim_found;
  logic [1:0]            trim_pick;
  logic [QUEUE_BITS-1:0] trim_best;
  logic [1:0]            top_pick;
  logic [1:0]            gmax_pick;
  logic [PROD_BITS-1:0]  can;
  logic [QUEUE_BITS-1:0] served_lane;
  logic                  all_min;

  ags_ser_mul #(
    .A_BITS (MUL_A_BITS),
    .B_BITS (CYCLE_BITS)
  ) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  ags_ser_div #(
    .NUM_BITS (NUM_BITS),
    .DEN_BITS (DEN_BITS),
    .QUO_BITS (CYCLE_BITS)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot)
  );

  // Operand select: queue times cycle during the split, rate times green in service
  assign mul_a   = (state_r == S_MUL_GO) ? MUL_A_BITS'(q_r[idx_r]) : MUL_A_BITS'(rate_r);
  assign mul_b   = (state_r == S_MUL_GO) ? cycle_r : g_r[idx_r];
  assign div_num = NUM_BITS'({mul_prod, 1'b0}) + NUM_BITS'(total_r);
  assign div_den = {total_r, 1'b0};

  assign in_ready  = (state_r == S_IDLE);
  assign in_accept = in_valid && in_ready;
  assign in_total  = TOTAL_BITS'(in_queue_north) + TOTAL_BITS'(in_queue_south)
                   + TOTAL_BITS'(in_queue_east) + TOTAL_BITS'(in_queue_west);

  // Sum of green seconds and the cycle length at the same width
  always_comb begin
    gsum  = SUM_BITS'(g_r[0]) + SUM_BITS'(g_r[1]) + SUM_BITS'(g_r[2]) + SUM_BITS'(g_r[3]);
    t_ext = SUM_BITS'(cycle_r);
    all_min = 1'b1;
    for (int i = 0; i < NUM_LANES; i++) begin
      if (g_r[i] != CYCLE_BITS'(1)) all_min = 1'b0;
    end
  end

  // Trim lane: smallest queue among lanes above one second, lowest index on ties
  always_comb begin
    trim_found = 1'b0;
    trim_pick  = 2'd0;
    trim_best  = '0;
    for (int i = 0; i < NUM_LANES; i++) begin
      if (g_r[i] > CYCLE_BITS'(1) && (!trim_found || q_r[i] < trim_best)) begin
        trim_found = 1'b1;
        trim_pick  = 2'(i);
        trim_best  = q_r[i];
      end
    end
  end

  // Top-up lane (largest queue) and main lane (most green), lowest index on ties
  always_comb begin
    top_pick  = 2'd0;
    gmax_pick = 2'd0;
    for (int i = 1; i < NUM_LANES; i++) begin
      if (q_r[i] > q_r[top_pick]) top_pick = 2'(i);
      if (g_r[i] > g_r[gmax_pick]) gmax_pick = 2'(i);
    end
  end

  // Service of the current lane: capacity limited by the queue
  always_comb begin
    can = mul_prod >> RATE_FRAC_BITS;
    served_lane = (can < PROD_BITS'(q_r[idx_r])) ? can[QUEUE_BITS-1:0] : q_r[idx_r];
  end

  // Next state and datapath updates
  always_comb begin
    state_nxt  = state_r;
    idx_nxt    = idx_r;
    dir_nxt    = dir_r;
    served_nxt = served_r;
    g_nxt      = g_r;
    left_nxt   = left_r;
    mul_start  = 1'b0;
    div_start  = 1'b0;
    out_load   = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;

    case (state_r)
      S_IDLE: begin
        idx_nxt = 2'd0;
        if (in_valid) begin
          state_nxt = (in_total == '0) ? S_EVEN : S_MUL_GO;
        end
      end
      // all queues empty: even split, remainder to north
      S_EVEN: begin
        for (int i = 0; i < NUM_LANES; i++) g_nxt[i] = cycle_r >> 2;
        g_nxt[LANE_N] = (cycle_r >> 2) + CYCLE_BITS'(cycle_r[1:0]);
        state_nxt = S_DIR;
      end
      S_MUL_GO: begin
        mul_start = 1'b1;
        state_nxt = S_MUL_WAIT;
      end
      S_MUL_WAIT: begin
        if (mul_done) state_nxt = S_DIV_GO;
      end
      S_DIV_GO: begin
        div_start = 1'b1;
        state_nxt = S_DIV_WAIT;
      end
      // store rounded share, at least one second
      S_DIV_WAIT: begin
        if (div_done) begin
          g_nxt[idx_r] = (div_quot == '0) ? CYCLE_BITS'(1) : div_quot;
          if (idx_r == LANE_W) begin
            idx_nxt   = 2'd0;
            state_nxt = S_ADJ;
          end else begin
            idx_nxt   = idx_r + 2'd1;
            state_nxt = S_MUL_GO;
          end
        end
      end
      // trim or top up one second per cycle until the sum fits or no lane can be trimmed
      S_ADJ: begin
        if (gsum > t_ext) begin
          if (trim_found) begin
            g_nxt[trim_pick] = g_r[trim_pick] - CYCLE_BITS'(1);
          end else begin
            state_nxt = S_DIR;
          end
        end else if (gsum < t_ext) begin
          g_nxt[top_pick] = g_r[top_pick] + CYCLE_BITS'(1);
        end else begin
          state_nxt = S_DIR;
        end
      end
      // override takes the whole cycle, else the lane with most green
      S_DIR: begin
        if (mask_r != 4'd0) begin
          if (mask_r[0])      dir_nxt = LANE_N;
          else if (mask_r[1]) dir_nxt = LANE_S;
          else if (mask_r[2]) dir_nxt = LANE_E;
          else                dir_nxt = LANE_W;
          for (int i = 0; i < NUM_LANES; i++) g_nxt[i] = '0;
          g_nxt[dir_nxt] = cycle_r;
        end else begin
          dir_nxt = lane_t'(gmax_pick);
        end
        idx_nxt    = 2'd0;
        served_nxt = '0;
        state_nxt  = S_SRV_GO;
      end
      S_SRV_GO: begin
        mul_start = 1'b1;
        state_nxt = S_SRV_WAIT;
      end
      S_SRV_WAIT: begin
        if (mul_done) begin
          left_nxt[idx_r] = q_r[idx_r] - served_lane;
          served_nxt      = served_r + SERVED_BITS'(served_lane);
          if (idx_r == LANE_W) begin
            state_nxt = S_DONE;
          end else begin
            idx_nxt   = idx_r + 2'd1;
            state_nxt = S_SRV_GO;
          end
        end
      end
      // hand the result to the output register once it is free
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_load      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      cycle_r     <= CYCLE_BITS'(CYCLE_RESET);
      rate_r      <= RATE_BITS'(1) << (RATE_FRAC_BITS - 1);
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_CYCLE_SECONDS: cycle_r <= cfg_wdata[CYCLE_BITS-1:0];
          CFG_SERVICE_RATE:  rate_r  <= cfg_wdata[RATE_BITS-1:0];
          default: ;
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    idx_r    <= idx_nxt;
    dir_r    <= dir_nxt;
    served_r <= served_nxt;
    g_r      <= g_nxt;
    left_r   <= left_nxt;
    if (in_accept) begin
      q_r[LANE_N] <= in_queue_north;
      q_r[LANE_S] <= in_queue_south;
      q_r[LANE_E] <= in_queue_east;
      q_r[LANE_W] <= in_queue_west;
      mask_r      <= in_override_mask;
      total_r     <= in_total;
    end
    if (out_load) begin
      out_g_r      <= g_r;
      out_left_r   <= left_r;
      out_dir_r    <= dir_r;
      out_served_r <= served_r;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_green_north     = out_g_r[LANE_N];
  assign out_green_south     = out_g_r[LANE_S];
  assign out_green_east      = out_g_r[LANE_E];
  assign out_green_west      = out_g_r[LANE_W];
  assign out_green_direction = out_dir_r;
  assign out_left_north      = out_left_r[LANE_N];
  assign out_left_south      = out_left_r[LANE_S];
  assign out_left_east       = out_left_r[LANE_E];
  assign out_left_west       = out_left_r[LANE_W];
  assign out_served_count    = out_served_r;

  // Every lane keeps its one-second minimum while the split is adjusted
  `ASSERT_IMPLY(a_adj_min_one, state_r == S_ADJ,
    (g_r[0] != '0) && (g_r[1] != '0) && (g_r[2] != '0) && (g_r[3] != '0),
    "lane below one second during adjustment")
  // A rounded share never exceeds the cycle
  `ASSERT_IMPLY(a_div_share, div_done, div_quot <= cycle_r,
    "rounded share exceeds cycle length")
  // Adjustment ends only on an exact fit or with every lane at its minimum
  `ASSERT_IMPLY(a_adj_exit, (state_r == S_ADJ) && (state_nxt == S_DIR),
    (gsum == t_ext) || ((gsum > t_ext) && all_min),
    "adjustment left with a wrong sum")
  // A finished item reaches the output register and frees the input side
  `ASSERT_NEXT(a_done_hand, (state_r == S_DONE) && (!out_valid_r || out_ready),
    out_valid_r && (state_r == S_IDLE),
    "finished result not handed over")

endmodule
